### hw/rtl/gbdc_pkg.sv
// ----------------------------------------------------------------------------
// gbdc_pkg
// Shared widths, constants, types and helpers for the gyro bias calibrator.
// ----------------------------------------------------------------------------
package gbdc_pkg;

  localparam int unsigned NUM_AXES          = 3;
  localparam int unsigned RAW_W             = 16;
  localparam int unsigned FRAC_W            = 8;
  localparam int unsigned RATE_W            = 25;
  localparam int unsigned BAND_W            = 26;
  localparam int unsigned SUM_W             = 28;
  localparam int unsigned CNT_W             = 13;
  localparam int unsigned REM_W             = CNT_W - 1;
  localparam int unsigned DIV_W             = SUM_W + FRAC_W;
  localparam int unsigned DIVCNT_W          = $clog2(DIV_W);
  localparam int unsigned MAX_CALIB_SAMPLES = 4096;
  localparam int unsigned CALIB_RESET       = 1000;

  localparam int unsigned IN_TDATA_W  = NUM_AXES * RAW_W;
  localparam int unsigned OUT_TDATA_W = ((NUM_AXES * RATE_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CALIB   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_e;

  // Per-cycle commands from the sequencer to every axis lane.
  typedef struct packed {
    logic first;       // first sample of a run
    logic accum;       // fold the staged sample into sum, min and max
    logic div_start;   // load the divider from the updated sum
    logic div_step;    // one restoring division step
    logic commit;      // write bias and band from the quotient
    logic calibrated;  // a run has completed before
  } lane_ctl_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][RATE_W-1:0] rate;
    logic                            run_done;
    logic                            is_calibrated;
  } result_t;

  // Effective run length: zero acts as one, large values clamp.
  function automatic logic [CNT_W-1:0] run_length(input logic [CNT_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    n = cfg;
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (cfg > CNT_W'(MAX_CALIB_SAMPLES)) begin
      n = CNT_W'(MAX_CALIB_SAMPLES);
    end
    return n;
  endfunction

endpackage

### hw/rtl/gbdc_lane.sv
// ----------------------------------------------------------------------------
// gbdc_lane
// One axis: running sum and extremes, serial bias divider, dead-band correction.
// ----------------------------------------------------------------------------
module gbdc_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbdc_pkg::lane_ctl_t           ctl_i,
  input  logic [gbdc_pkg::CNT_W-1:0]    cnt_i,
  input  logic signed [gbdc_pkg::RAW_W-1:0] raw_i,
  output logic [gbdc_pkg::RATE_W-1:0]   rate_o
);
  import gbdc_pkg::*;

  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [RAW_W-1:0]  min_q, max_q;
  logic signed [RATE_W-1:0] bias_q, bias_new;
  logic signed [BAND_W-1:0] band_low_q, band_high_q;
  logic [DIV_W-1:0]         dq_q;
  logic [REM_W-1:0]         rem_q;
  logic                     neg_q;

  logic [SUM_W-1:0]         sum_mag;
  logic [CNT_W-1:0]         rem_sh;
  logic                     ge;
  logic [CNT_W-1:0]         rem_diff;
  logic [RATE_W-1:0]        quot;
  logic signed [BAND_W-1:0] bias_ext, min_sc, max_sc, raw_sc, v;
  logic                     in_band;

  assign sum_d   = (ctl_i.first ? SUM_W'(0) : sum_q)
                 + {{(SUM_W-RAW_W){raw_i[RAW_W-1]}}, raw_i};
  assign sum_mag = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);

  // Restoring division, one quotient bit per step; quotient shifts into dq.
  assign rem_sh   = {rem_q, dq_q[DIV_W-1]};
  assign ge       = rem_sh >= cnt_i;
  assign rem_diff = rem_sh - cnt_i;

  // Quotient magnitude never exceeds 2^23, so 24 bits plus a sign suffice.
  assign quot     = {1'b0, dq_q[RATE_W-2:0]};
  assign bias_new = neg_q ? RATE_W'(-quot) : RATE_W'(quot);
  assign bias_ext = {bias_new[RATE_W-1], bias_new};
  assign min_sc   = {{(BAND_W-RAW_W-FRAC_W){min_q[RAW_W-1]}}, min_q, FRAC_W'(0)};
  assign max_sc   = {{(BAND_W-RAW_W-FRAC_W){max_q[RAW_W-1]}}, max_q, FRAC_W'(0)};

  assign raw_sc  = {{(BAND_W-RAW_W-FRAC_W){raw_i[RAW_W-1]}}, raw_i, FRAC_W'(0)};
  assign v       = raw_sc - {bias_q[RATE_W-1], bias_q};
  assign in_band = (v >= band_low_q) && (v <= band_high_q);

  always_comb begin
    if (!ctl_i.calibrated) begin
      rate_o = raw_sc[RATE_W-1:0];
    end else if (in_band) begin
      rate_o = '0;
    end else begin
      rate_o = v[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      bias_q      <= '0;
      band_low_q  <= '0;
      band_high_q <= '0;
    end else begin
      if (ctl_i.accum) begin
        sum_q <= sum_d;
      end
      if (ctl_i.commit) begin
        bias_q      <= bias_new;
        band_low_q  <= min_sc - bias_ext;
        band_high_q <= max_sc - bias_ext;
        sum_q       <= '0;
      end
    end
  end

  // Extremes are loaded by the first sample of each run and need no reset.
  always_ff @(posedge clk_i) begin
    if (ctl_i.accum) begin
      if (ctl_i.first || (raw_i < min_q)) begin
        min_q <= raw_i;
      end
      if (ctl_i.first || (raw_i > max_q)) begin
        max_q <= raw_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      dq_q  <= {sum_mag, FRAC_W'(0)};
      rem_q <= '0;
      neg_q <= sum_d[SUM_W-1];
    end else if (ctl_i.div_step) begin
      dq_q  <= {dq_q[DIV_W-2:0], ge};
      rem_q <= ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    end
  end

endmodule

### hw/rtl/gbdc_out.sv
// ----------------------------------------------------------------------------
// gbdc_out
// Merges the lane results into one beat and holds it in the output register.
// ----------------------------------------------------------------------------
module gbdc_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  gbdc_pkg::result_t                  result_i,
  output logic                               free_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [gbdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [gbdc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
  import gbdc_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o        = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(res_q.rate[NUM_AXES-1:0]);
  assign m_axis_tuser  = {res_q.is_calibrated, res_q.run_done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

### hw/rtl/gyro_bias_deadband_calibrator.sv
// ----------------------------------------------------------------------------
// gyro_bias_deadband_calibrator
// Three-axis gyro bias calibration with a dead band around the measured bias.
// ----------------------------------------------------------------------------
// Flow: a measure beat or a calibration beat that does not end a run is staged,
//   then its result goes to the output register once that is free.
// Input: taken only while idle; the run-ending beat holds the input for the
//   36 steps of the per-axis restoring divider that forms the bias.
// Reset: asynchronous, active low; clears sums, bias, band, sample count and
//   the calibrated flag, and loads the sample count register with 1000.
module gyro_bias_deadband_calibrator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: calib_samples.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gbdc_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0 up: raw_x[15:0], raw_y[31:16], raw_z[47:32].
  input  logic [gbdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: opcode[0].
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0 up: rate_x[24:0], rate_y[49:25], rate_z[74:50], zeros.
  output logic [gbdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser from bit 0 up: run_done[0], is_calibrated[1].
  output logic [gbdc_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
  import gbdc_pkg::*;

  state_e                          state_q, state_d;
  logic [CNT_W-1:0]                calib_q;
  logic [CNT_W-1:0]                samples_q, samples_next;
  logic [CNT_W-1:0]                cnt_q;
  logic [DIVCNT_W-1:0]             div_cnt_q;
  logic                            calibrated_q;
  logic                            op_q;
  logic [NUM_AXES-1:0][RAW_W-1:0]  raw_q;

  logic                            out_free;
  logic                            out_load;
  logic                            exec_fire;
  logic                            run_end;
  logic                            div_last;
  lane_ctl_t                       ctl;
  result_t                         result;
  logic [NUM_AXES-1:0][RATE_W-1:0] lane_rate;

  assign cfg_ready_o  = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);

  // The sample that brings the count to the run length closes the run; a
  // count lowered during a run closes it on the next calibration sample.
  assign samples_next = samples_q + CNT_W'(1);
  assign run_end      = (op_q == OP_CALIB) && (samples_next >= run_length(calib_q));
  assign exec_fire    = (state_q == ST_EXEC) && out_free;
  assign div_last     = (div_cnt_q == DIVCNT_W'(DIV_W - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = run_end ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Lane commands and the merged result beat.
  always_comb begin
    ctl.first      = (samples_q == '0);
    ctl.accum      = exec_fire && (op_q == OP_CALIB);
    ctl.div_start  = exec_fire && run_end;
    ctl.div_step   = (state_q == ST_DIV);
    ctl.commit     = (state_q == ST_FIN) && out_free;
    ctl.calibrated = calibrated_q;

    out_load = ctl.commit || (exec_fire && !run_end);

    result.run_done      = (state_q == ST_FIN);
    result.is_calibrated = calibrated_q || (state_q == ST_FIN);
    if ((state_q == ST_FIN) || (op_q == OP_CALIB)) begin
      result.rate = '0;
    end else begin
      result.rate = lane_rate;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      calib_q      <= CNT_W'(CALIB_RESET);
      samples_q    <= '0;
      div_cnt_q    <= '0;
      calibrated_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        calib_q <= cfg_data_i;
      end
      if (ctl.accum) begin
        samples_q <= run_end ? '0 : samples_next;
      end
      if (ctl.div_start) begin
        div_cnt_q <= '0;
      end else if (ctl.div_step) begin
        div_cnt_q <= div_cnt_q + DIVCNT_W'(1);
      end
      if (ctl.commit) begin
        calibrated_q <= 1'b1;
      end
    end
  end

  // Staged beat and the divisor of a closing run.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tuser[0];
      raw_q <= s_axis_tdata;
    end
    if (ctl.div_start) begin
      cnt_q <= samples_next;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    gbdc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .cnt_i  (cnt_q),
      .raw_i  (raw_q[a]),
      .rate_o (lane_rate[a])
    );
  end

  gbdc_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .result_i      (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### hw/rtl/gbdc_checker.sv
// ----------------------------------------------------------------------------
// gbdc_checker
// Port-level checks for the gyro bias calibrator, bound to the top level.
// ----------------------------------------------------------------------------
module gbdc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [gbdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [gbdc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // Completing a run always reports the block as calibrated.
  a_done_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && !m_axis_tuser[1]))
    else $error("run_done without is_calibrated");

  // The beat that closes a run carries zero rates.
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0))
    else $error("run-closing beat carries nonzero rates");

  // Items are taken one at a time: the cycle after an accept is never ready.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in two consecutive cycles");

endmodule

bind gyro_bias_deadband_calibrator gbdc_checker u_gbdc_checker (.*);

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias dead-band calibrator testbench
// Streams calibration and measure beats into the block, predicts every result
// beat with a behavioral model of the calibrator kept in this file, and checks
// each result field by field under random source and sink idling.
// ----------------------------------------------------------------------------
module testbench;
  import gbdc_pkg::*;

  // Any gap longer than this with no beat on any channel means a hang. The
  // slowest legal gap is a run-ending beat plus a sink stall plus a source
  // gap, so this leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_BEATS   = 1680;
  localparam int unsigned CALM_TAIL      = 300;
  localparam int unsigned MAX_PRINTED    = 100;

  // One input beat: opcode in tuser, the three raw axes packed into tdata.
  typedef struct packed {
    logic                            op;
    logic [NUM_AXES-1:0][RAW_W-1:0]  raw;
  } gyro_beat_t;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [NUM_AXES-1:0][RATE_W-1:0] rate;
    logic                            run_done;
    logic                            calibrated;
  } rate_beat_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CNT_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  gyro_bias_deadband_calibrator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calibrator model state. It mirrors the block: run accumulators, the bias
  // and band of the last completed run, and the sample count register.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] samples_cfg = CNT_W'(CALIB_RESET);
  longint      acc_sum   [NUM_AXES] = '{default: 0};
  int          run_min   [NUM_AXES] = '{default: 0};
  int          run_max   [NUM_AXES] = '{default: 0};
  int unsigned run_count = 0;
  longint      offset_q8 [NUM_AXES] = '{default: 0};
  longint      band_lo   [NUM_AXES] = '{default: 0};
  longint      band_hi   [NUM_AXES] = '{default: 0};
  bit          have_cal  = 1'b0;

  // Bookkeeping shared by the stimulus, the driver and the monitor.
  gyro_beat_t  pending_beats [$];
  rate_beat_t  expected_rates [$];
  gyro_beat_t  beat_on_bus;
  bit          idling        = 1'b1;
  int unsigned src_gap       = 0;
  int unsigned sink_gap      = 0;
  int unsigned items_queued  = 0;
  int unsigned beats_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned runs_done     = 0;
  int unsigned cfg_writes    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned errors        = 0;

  // Advances the model by one accepted beat and returns the result it owes.
  function automatic rate_beat_t predict_rates(input gyro_beat_t b);
    rate_beat_t  r;
    int          raw_v;
    int unsigned eff_len;
    longint      v;
    r = '0;
    if (b.op == OP_CALIB) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        raw_v = int'($signed(b.raw[a]));
        // The first sample of a run seeds min and max and restarts the sum.
        if (run_count == 0) begin
          acc_sum[a] = 0;
          run_min[a] = raw_v;
          run_max[a] = raw_v;
        end else begin
          if (raw_v < run_min[a]) run_min[a] = raw_v;
          if (raw_v > run_max[a]) run_max[a] = raw_v;
        end
        acc_sum[a] += raw_v;
      end
      run_count++;
      // A count of zero behaves as one; anything above the maximum clamps.
      if (samples_cfg == '0) begin
        eff_len = 1;
      end else if (samples_cfg > MAX_CALIB_SAMPLES) begin
        eff_len = MAX_CALIB_SAMPLES;
      end else begin
        eff_len = samples_cfg;
      end
      if (run_count >= eff_len) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          // Signed division truncates toward zero, as the block must.
          offset_q8[a] = (acc_sum[a] * 256) / longint'(run_count);
          band_lo[a]   = longint'(run_min[a]) * 256 - offset_q8[a];
          band_hi[a]   = longint'(run_max[a]) * 256 - offset_q8[a];
          acc_sum[a]   = 0;
        end
        run_count  = 0;
        have_cal   = 1'b1;
        r.run_done = 1'b1;
        runs_done++;
      end
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        v = longint'($signed(b.raw[a])) * 256;
        // Before the first completed run the raw value passes straight through.
        if (have_cal) begin
          v -= offset_q8[a];
          if (v >= band_lo[a] && v <= band_hi[a]) v = 0;
        end
        r.rate[a] = v[RATE_W-1:0];
      end
    end
    r.calibrated = have_cal;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    end
  endtask

  task automatic queue_beat(input logic op, input logic [RAW_W-1:0] x,
                            input logic [RAW_W-1:0] y, input logic [RAW_W-1:0] z);
    gyro_beat_t b;
    b.op     = op;
    b.raw[0] = x;
    b.raw[1] = y;
    b.raw[2] = z;
    pending_beats.push_back(b);
    items_queued++;
  endtask

  // Holds the caller until every queued beat has come back as a result.
  task automatic wait_drained();
    do @(posedge clk_i); while (results_seen != items_queued);
  endtask

  // The register is only ever written with the block idle.
  task automatic write_samples_cfg(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    samples_cfg = value;
    cfg_writes++;
  endtask

  // A raw count scattered around a center, saturated to the 16-bit range.
  function automatic logic [RAW_W-1:0] jitter(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[RAW_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Source driver. A new beat goes on the bus when the bus is empty or the
  // current beat is taken at this edge; the model sees beats in the order the
  // block accepts them.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rates.push_back(predict_rates(beat_on_bus));
        beats_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
          // Idle burst drawn by src_gap, this one included.
          src_gap = $urandom_range(0, 11);
          s_axis_tvalid <= 1'b0;
        end else begin
          beat_on_bus = pending_beats.pop_front();
          s_axis_tdata  <= beat_on_bus.raw;
          s_axis_tuser  <= beat_on_bus.op;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and sink. Each result beat is checked against the oldest
  // expectation; the sink drops tready in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rate_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rates.size() == 0) begin
          flag_mismatch("result beat with nothing outstanding", m_axis_tdata[63:0], 0);
        end else begin
          want = expected_rates.pop_front();
          for (int a = 0; a < NUM_AXES; a++) begin
            if (m_axis_tdata[a*RATE_W +: RATE_W] !== want.rate[a]) begin
              flag_mismatch($sformatf("rate axis %0d", a),
                            m_axis_tdata[a*RATE_W +: RATE_W], want.rate[a]);
            end
          end
          if (m_axis_tuser[0] !== want.run_done) begin
            flag_mismatch("run_done", m_axis_tuser[0], want.run_done);
          end
          if (m_axis_tuser[1] !== want.calibrated) begin
            flag_mismatch("is_calibrated", m_axis_tuser[1], want.calibrated);
          end
        end
        results_seen++;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch with no beat on any channel ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d of %0d results seen",
                 quiet_cycles, results_seen, items_queued);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. Directed beats first, then random phases, each phase starting
  // from an idle block with a fresh register value.
  // --------------------------------------------------------------------------
  initial begin
    int          center [NUM_AXES];
    int          spread;
    int unsigned phase_len;
    int unsigned random_sent;
    logic [CNT_W-1:0] cfg_pick;
    random_sent = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Uncalibrated pass-through at the extremes of the raw range.
    queue_beat(OP_MEASURE, 16'h7FFF, 16'h8000, 16'h0000);
    queue_beat(OP_MEASURE, 16'hFFFF, 16'h0001, 16'h8000);
    // One sample under the reset count of 1000, then a measure mid-run.
    queue_beat(OP_CALIB, 16'd100, -16'sd200, 16'd5);
    queue_beat(OP_MEASURE, 16'd7, 16'd7, 16'd7);
    // Lowering the count to the number of samples already taken: the next sample
    // closes the run with two samples.
    write_samples_cfg(CNT_W'(1));
    queue_beat(OP_CALIB, 16'd300, -16'sd100, -16'sd5);
    // Probe both band edges and one count beyond them on every axis.
    queue_beat(OP_MEASURE, 16'd100, -16'sd200, 16'd5);
    queue_beat(OP_MEASURE, 16'd99, -16'sd201, -16'sd6);
    queue_beat(OP_MEASURE, 16'd300, -16'sd100, -16'sd5);
    queue_beat(OP_MEASURE, 16'd301, -16'sd99, 16'd6);
    // A count of zero behaves as one: each sample is a full run.
    write_samples_cfg(CNT_W'(0));
    queue_beat(OP_CALIB, 16'h7FFF, 16'h8000, 16'hFFFF);
    queue_beat(OP_MEASURE, 16'h7FFF, 16'h8000, 16'h0000);
    queue_beat(OP_MEASURE, 16'h8000, 16'h7FFF, 16'hFFFF);
    // A three-sample run whose sums do not divide evenly, negative ones too,
    // so the bias truncates toward zero.
    write_samples_cfg(CNT_W'(3));
    queue_beat(OP_CALIB, 16'hFFFF, 16'h0000, 16'h7FFF);
    queue_beat(OP_CALIB, 16'h0000, 16'hFFFF, 16'h7FFF);
    queue_beat(OP_CALIB, 16'h0000, 16'h0000, 16'h7FFE);
    queue_beat(OP_MEASURE, 16'h0000, 16'h0000, 16'h7FFF);
    queue_beat(OP_MEASURE, 16'hFFFF, 16'hFFFF, 16'h8000);
    // A long run requested through a value above the maximum, fed with
    // samples at the ends of the raw range; a lowered count then closes it.
    write_samples_cfg(CNT_W'(8191));
    repeat (40) queue_beat(OP_CALIB, 16'h8000, 16'h7FFF, 16'($urandom));
    write_samples_cfg(CNT_W'(40));
    queue_beat(OP_CALIB, 16'h8000, 16'h7FFF, 16'($urandom));
    queue_beat(OP_MEASURE, 16'h8000, 16'h7FFF, 16'h0000);
    queue_beat(OP_MEASURE, 16'h7FFF, 16'h8000, 16'h1234);
    // A partial run under the maximum count, then a smaller count mid-run:
    // the old calibration stays in use until the next sample closes the run.
    write_samples_cfg(CNT_W'(MAX_CALIB_SAMPLES));
    repeat (10) queue_beat(OP_CALIB, jitter(-50, 20), jitter(900, 20), jitter(0, 3));
    queue_beat(OP_MEASURE, 16'h0000, 16'h0000, 16'h0000);
    write_samples_cfg(CNT_W'(5));
    queue_beat(OP_CALIB, jitter(-50, 20), jitter(900, 20), jitter(0, 3));
    queue_beat(OP_MEASURE, 16'hFFCE, 16'd900, 16'h0000);

    // Random phases. Most beats are calibration samples clustered around a
    // center, with measures near the resulting band; the rest is noise.
    while (random_sent < RANDOM_BEATS) begin
      if (random_sent >= RANDOM_BEATS - CALM_TAIL) begin
        idling = 1'b0;
      end else begin
        idling = ($urandom_range(0, 4) != 0);
      end
      case ($urandom_range(0, 9))
        0:       cfg_pick = CNT_W'(0);
        1:       cfg_pick = CNT_W'(1);
        2:       cfg_pick = CNT_W'($urandom_range(MAX_CALIB_SAMPLES + 1, 8191));
        default: cfg_pick = CNT_W'($urandom_range(2, 24));
      endcase
      write_samples_cfg(cfg_pick);
      for (int a = 0; a < NUM_AXES; a++) begin
        if ($urandom_range(0, 3) == 0) begin
          center[a] = int'($signed(16'($urandom)));
        end else begin
          center[a] = int'($urandom_range(0, 400)) - 200;
        end
      end
      spread    = $urandom_range(0, 40);
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4:
            queue_beat(OP_CALIB, jitter(center[0], spread), jitter(center[1], spread),
                       jitter(center[2], spread));
          5, 6, 7:
            queue_beat(OP_MEASURE, jitter(center[0], 2 * spread + 2),
                       jitter(center[1], 2 * spread + 2), jitter(center[2], 2 * spread + 2));
          8:
            queue_beat(OP_MEASURE, 16'($urandom), 16'($urandom), 16'($urandom));
          default:
            queue_beat(OP_CALIB, 16'($urandom), 16'($urandom), 16'($urandom));
        endcase
      end
      random_sent += phase_len;
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (expected_rates.size() != 0) begin
      flag_mismatch("expectations left over", 0, expected_rates.size());
    end

    $display("Covered %0d input beats and %0d result beats across %0d register writes;",
             beats_taken, results_seen, cfg_writes);
    $display("%0d calibration runs completed, some closed early by a lowered count.",
             runs_done);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### gyro_bias_deadband_calibrator.f
hw/rtl/gbdc_pkg.sv
hw/rtl/gbdc_lane.sv
hw/rtl/gbdc_out.sv
hw/rtl/gyro_bias_deadband_calibrator.sv
hw/rtl/gbdc_checker.sv
sim/testbench.sv
